// File: hdl/mckd_pkg.sv
// Package with shared constants and payload types of the minimum-cover knapsack block.
package mckd_pkg;

  localparam int MaxItems     = 32;
  localparam int MaxWeightSum = 1024;
  localparam int Cols         = MaxWeightSum + 1;
  localparam int IdxW         = $clog2(MaxItems);
  localparam int CntW         = $clog2(MaxItems + 1);
  localparam int ColW         = $clog2(Cols + 1);
  localparam int DecAw        = IdxW + ColW;
  localparam int CostW        = 22;
  localparam int WsumW        = 14;
  localparam logic [20:0] ValMax = 21'h1FFFFF;

  typedef struct packed {
    logic [15:0]        item_value;
    logic [7:0]         item_weight;
    logic signed [11:0] required_weight;
    logic               last_item;
  } in_item_t;

  typedef struct packed {
    logic        excluded;
    logic [20:0] min_cover_value;
    logic        infeasible;
    logic        last_result;
  } out_item_t;

endpackage

// File: hdl/mckd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module mckd_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/min_cover_knapsack_dp.sv
// Top level: item loading, table fill sequencer and backtrack of the minimum-cover knapsack.
// Loading takes one item per cycle while start is high; busy stays low until an item with
// last_item arrives. After it, row zero is filled, then each of the n rows fetches its item
// and computes each cell through the shared cost memory and compare-subtract unit; results
// follow one per item. If the set is infeasible, the table fill is skipped.
// out_valid is a one-cycle strobe and cannot be stalled. Synchronous active-low reset clears the set.
module min_cover_knapsack_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  mckd_pkg::in_item_t in_item,
  output logic               out_valid,
  output mckd_pkg::out_item_t out_item
);

  localparam int IdxW  = mckd_pkg::IdxW;
  localparam int CntW  = mckd_pkg::CntW;
  localparam int ColW  = mckd_pkg::ColW;
  localparam int CostW = mckd_pkg::CostW;
  localparam int WsumW = mckd_pkg::WsumW;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_INIT  = 9'b000000010,
    ST_ROW   = 9'b000000100,
    ST_RD    = 9'b000001000,
    ST_WAIT  = 9'b000010000,
    ST_CELL  = 9'b000100000,
    ST_BEST  = 9'b001000000,
    ST_BRD   = 9'b010000000,
    ST_BOUT  = 9'b100000000
  } state_t;

  state_t                state_r, state_nxt;
  logic [CntW-1:0]       count_r, count_nxt;
  logic [WsumW-1:0]      wsum_r, wsum_nxt;
  logic [CostW-1:0]      vsum_r, vsum_nxt;
  logic [10:0]           req_r, req_nxt;
  logic                  infeas_r, infeas_nxt;
  logic [IdxW-1:0]       row_r, row_nxt;
  logic [ColW-1:0]       col_r, col_nxt;
  logic                  cur_r, cur_nxt;
  logic [15:0]           iv_r, iv_nxt;
  logic [7:0]            iw_r, iw_nxt;
  logic [CostW-1:0]      keep_r, keep_nxt;
  logic [1:0]            phase_r, phase_nxt;
  logic [20:0]           best_r, best_nxt;
  logic [WsumW:0]        m_r, m_nxt;

  // Item store.
  logic                  st_we;
  logic [IdxW-1:0]       st_waddr, st_raddr;
  logic [23:0]           st_rdata;

  // Cost rows, two banks addressed by bank bit and column.
  logic                  c_we;
  logic [ColW:0]         c_waddr, c_raddr;
  logic [CostW-1:0]      c_wdata, c_rdata;

  // Decision bits.
  logic                  d_we, d_wdata, d_rdata;
  logic [IdxW+ColW-1:0]  d_waddr, d_raddr;

  logic [WsumW:0]        reach;
  logic [CostW-1:0]      opt;
  logic                  take;
  logic [11:0]           rraw;

  mckd_ram #(.Width(24), .Depth(mckd_pkg::MaxItems)) u_store (
    .clk, .we(st_we), .waddr(st_waddr), .wdata({in_item.item_value, in_item.item_weight}),
    .raddr(st_raddr), .rdata(st_rdata));

  mckd_ram #(.Width(CostW), .Depth(2 ** (ColW + 1))) u_cost (
    .clk, .we(c_we), .waddr(c_waddr), .wdata(c_wdata), .raddr(c_raddr), .rdata(c_rdata));

  mckd_ram #(.Width(1), .Depth(2 ** (IdxW + ColW))) u_dec (
    .clk, .we(d_we), .waddr(d_waddr), .wdata(d_wdata), .raddr(d_raddr), .rdata(d_rdata));

  // Shared compare-subtract unit: excluded option against kept option.
  assign opt  = c_rdata - CostW'(iv_r);
  assign take = opt < keep_r;
  assign reach = (WsumW+1)'(col_r) + (WsumW+1)'(iw_r);
  assign rraw = in_item.required_weight;

  assign busy = (state_r != ST_IDLE);

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    wsum_nxt  = wsum_r;
    vsum_nxt  = vsum_r;
    req_nxt   = req_r;
    infeas_nxt = infeas_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    cur_nxt   = cur_r;
    iv_nxt    = iv_r;
    iw_nxt    = iw_r;
    keep_nxt  = keep_r;
    phase_nxt = phase_r;
    best_nxt  = best_r;
    m_nxt     = m_r;
    st_we     = 1'b0;
    st_waddr  = count_r[IdxW-1:0];
    st_raddr  = row_r;
    c_we      = 1'b0;
    c_waddr   = {cur_r, col_r};
    c_wdata   = vsum_r;
    c_raddr   = {~cur_r, col_r};
    d_we      = 1'b0;
    d_waddr   = {row_r, col_r};
    d_wdata   = 1'b0;
    d_raddr   = {row_r, m_r[ColW-1:0]};
    out_valid = 1'b0;
    out_item  = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (count_r < CntW'(mckd_pkg::MaxItems)) begin
            st_we     = 1'b1;
            count_nxt = count_r + 1'b1;
            wsum_nxt  = wsum_r + WsumW'(in_item.item_weight);
            vsum_nxt  = vsum_r + CostW'(in_item.item_value);
          end
          if (in_item.last_item) begin
            req_nxt = rraw[11] ? 11'd0 : rraw[10:0];
            infeas_nxt = ((rraw[11] ? WsumW'(0) : WsumW'(rraw[10:0])) > wsum_nxt) ||
                         (wsum_nxt > WsumW'(mckd_pkg::MaxWeightSum));
            col_nxt   = '0;
            cur_nxt   = 1'b0;
            row_nxt   = '0;
            best_nxt  = '0;
            state_nxt = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        // Row zero: every column holds the full value sum.
        if (infeas_r || count_r == '0) begin
          state_nxt = (count_r == '0) ? ST_IDLE : ST_BEST;
        end else begin
          c_we = 1'b1;
          if (WsumW'(col_r) == wsum_r) state_nxt = ST_ROW;
          else col_nxt = col_r + 1'b1;
        end
      end
      ST_ROW: begin
        st_raddr  = row_r;
        phase_nxt = phase_r + 1'b1;
        if (phase_r == 2'd1) begin
          iv_nxt    = st_rdata[23:8];
          iw_nxt    = st_rdata[7:0];
          cur_nxt   = ~cur_r;
          col_nxt   = '0;
          phase_nxt = '0;
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        // Read the kept option of the previous row.
        c_raddr   = {~cur_r, col_r};
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        keep_nxt  = c_rdata;
        c_raddr   = {~cur_r, reach[ColW-1:0]};
        state_nxt = ST_CELL;
      end
      ST_CELL: begin
        c_we    = 1'b1;
        d_we    = 1'b1;
        if (reach <= (WsumW+1)'(wsum_r) && take) begin
          c_wdata = opt;
          d_wdata = 1'b1;
        end else begin
          c_wdata = keep_r;
        end
        if (WsumW'(col_r) == wsum_r) begin
          col_nxt = '0;
          if (CntW'(row_r) + 1'b1 == count_r) begin
            state_nxt = ST_BEST;
          end else begin
            row_nxt   = row_r + 1'b1;
            state_nxt = ST_ROW;
          end
        end else begin
          col_nxt   = col_r + 1'b1;
          state_nxt = ST_RD;
        end
      end
      ST_BEST: begin
        // Read the final cell, then start the backtrack at the last item.
        c_raddr   = {cur_r, req_r[ColW-1:0]};
        phase_nxt = phase_r + 1'b1;
        if (phase_r == 2'd1) begin
          if (!infeas_r) begin
            best_nxt = (c_rdata > CostW'(mckd_pkg::ValMax)) ? mckd_pkg::ValMax
                                                             : c_rdata[20:0];
          end
          phase_nxt = '0;
          m_nxt     = (WsumW+1)'(req_r);
          row_nxt   = IdxW'(count_r - 1'b1);
          state_nxt = ST_BRD;
        end
      end
      ST_BRD: begin
        st_raddr  = row_r;
        d_raddr   = {row_r, m_r[ColW-1:0]};
        state_nxt = ST_BOUT;
      end
      ST_BOUT: begin
        // One result transfer per item, last loaded item first.
        out_valid = 1'b1;
        out_item.min_cover_value = best_r;
        out_item.infeasible      = infeas_r;
        out_item.last_result     = (row_r == '0);
        if (!infeas_r && m_r < (WsumW+1)'(mckd_pkg::Cols) && d_rdata) begin
          out_item.excluded = 1'b1;
          m_nxt = m_r + (WsumW+1)'(st_rdata[7:0]);
        end
        if (row_r == '0) begin
          count_nxt = '0;
          wsum_nxt  = '0;
          vsum_nxt  = '0;
          state_nxt = ST_IDLE;
        end else begin
          row_nxt   = row_r - 1'b1;
          state_nxt = ST_BRD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      wsum_r  <= '0;
      vsum_r  <= '0;
      phase_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      wsum_r  <= wsum_nxt;
      vsum_r  <= vsum_nxt;
      phase_r <= phase_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    infeas_r <= infeas_nxt;
    row_r    <= row_nxt;
    col_r    <= col_nxt;
    cur_r    <= cur_nxt;
    iv_r     <= iv_nxt;
    iw_r     <= iw_nxt;
    keep_r   <= keep_nxt;
    best_r   <= best_nxt;
    m_r      <= m_nxt;
  end

endmodule
